/* sv/clq_pkg.sv */
// clq_pkg: shared types and constants for count_less_or_equal_query.
// No dependencies.
`timescale 1ns / 1ps
package clq_pkg;
    localparam int DEF_CAPACITY = 1024;
    localparam int DATA_W       = 32;
    localparam int COUNT_W      = 11;

    typedef enum logic
    {
        KIND_LOAD  = 1'b0,
        KIND_QUERY = 1'b1
    } kind_t;

    typedef struct packed
    {
        logic               query;
        logic               full;
        logic [DATA_W-1:0]  key;
    } cmd_t;
endpackage

/* sv/clq_ram.sv */
// clq_ram: generic single-port-write, single-port-read RAM, registered read.
// No dependencies.
`timescale 1ns / 1ps
module clq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end
endmodule

/* sv/clq_front.sv */
// clq_front: accepts items, biases the key, tags full-store loads, and
// holds up to two commands for the back end. Depends on clq_pkg.
`timescale 1ns / 1ps
module clq_front #(
    parameter int CAPACITY = clq_pkg::DEF_CAPACITY
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic                        kind,
    input  logic signed [clq_pkg::DATA_W-1:0] item_value,
    output logic                        cmd_valid,
    input  logic                        cmd_take,
    output clq_pkg::cmd_t               cmd
);
    import clq_pkg::*;
    localparam int CNT_W = $clog2(CAPACITY + 1);

    cmd_t           q_reg [2];
    logic [1:0]     fill_reg, fill_next;
    logic           rd_reg, rd_next, wr_reg, wr_next;
    logic [CNT_W-1:0] loads_reg, loads_next;
    logic           acc;
    cmd_t           c_in;

    assign in_stall  = (fill_reg == 2'd2);
    assign acc       = in_valid && !in_stall;
    assign cmd_valid = (fill_reg != 2'd0);
    assign cmd       = q_reg[rd_reg];

    always_comb
    begin
        c_in.query = (kind == KIND_QUERY);
        c_in.key   = {~item_value[DATA_W-1], item_value[DATA_W-2:0]};
        c_in.full  = (loads_reg == CNT_W'(CAPACITY));
        loads_next = loads_reg;
        if (acc && !c_in.query && !c_in.full)
        begin
            loads_next = loads_reg + 1'b1;
        end
        fill_next = fill_reg + {1'b0, acc} - {1'b0, cmd_take};
        rd_next   = rd_reg ^ cmd_take;
        wr_next   = wr_reg ^ acc;
    end

    always_ff @(posedge clk)
    begin
        if (acc)
        begin
            q_reg[wr_reg] <= c_in;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg  <= '0;
            rd_reg    <= 1'b0;
            wr_reg    <= 1'b0;
            loads_reg <= '0;
        end
        else
        begin
            fill_reg  <= fill_next;
            rd_reg    <= rd_next;
            wr_reg    <= wr_next;
            loads_reg <= loads_next;
        end
    end

    a_fill_max: assert property (@(posedge clk) disable iff (!rst_n) fill_reg <= 2'd2)
        else $error("queue overfilled");
    a_take_valid: assert property (@(posedge clk) disable iff (!rst_n) cmd_take |-> cmd_valid)
        else $error("take from empty queue");
    a_loads_cap: assert property (@(posedge clk) disable iff (!rst_n)
        loads_reg <= CNT_W'(CAPACITY))
        else $error("load count above capacity");
endmodule

/* sv/clq_back.sv */
// clq_back: binary search and shifting insert over the sorted store RAM,
// plus the output register. Depends on clq_pkg and clq_ram.
`timescale 1ns / 1ps
module clq_back #(
    parameter int CAPACITY = clq_pkg::DEF_CAPACITY
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cmd_valid,
    output logic                          cmd_take,
    input  clq_pkg::cmd_t                 cmd,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [clq_pkg::COUNT_W-1:0]   count_le,
    output logic                          overflow
);
    import clq_pkg::*;
    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int ADR_W = $clog2(CAPACITY);

    typedef enum logic [5:0]
    {
        S_IDLE  = 6'b000001,
        S_RD    = 6'b000010,
        S_CMP   = 6'b000100,
        S_SHRD  = 6'b001000,
        S_SHWR  = 6'b010000,
        S_OUT   = 6'b100000
    } state_t;

    state_t           state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next, lo_reg, lo_next, hi_reg, hi_next;
    logic [CNT_W-1:0] idx_reg, idx_next;
    logic [DATA_W-1:0] key_reg, key_next;
    logic             query_reg, query_next, ovf_reg, ovf_next;
    logic [CNT_W-1:0] mid;
    logic             we;
    logic [ADR_W-1:0] wa, ra;
    logic [DATA_W-1:0] wd, rdata;

    clq_ram #(.WIDTH(DATA_W), .DEPTH(CAPACITY)) u_ram (
        .clk(clk), .wr_en(we), .wr_addr(wa), .wr_data(wd),
        .rd_addr(ra), .rd_data(rdata)
    );

    assign mid       = lo_reg + ((hi_reg - lo_reg) >> 1);
    assign out_valid = (state_reg == S_OUT);
    assign count_le  = ovf_reg ? '0 : COUNT_W'(lo_reg);
    assign overflow  = ovf_reg;
    assign cmd_take  = (state_reg == S_IDLE) && cmd_valid;

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        lo_next    = lo_reg;
        hi_next    = hi_reg;
        idx_next   = idx_reg;
        key_next   = key_reg;
        query_next = query_reg;
        ovf_next   = ovf_reg;
        we = 1'b0;
        wa = idx_reg[ADR_W-1:0];
        wd = key_reg;
        ra = mid[ADR_W-1:0];
        case (state_reg)
            S_IDLE:
            begin
                if (cmd_valid)
                begin
                    key_next   = cmd.key;
                    query_next = cmd.query;
                    ovf_next   = !cmd.query && cmd.full;
                    lo_next    = '0;
                    hi_next    = cnt_reg;
                    state_next = (!cmd.query && cmd.full) ? S_OUT : S_RD;
                end
            end
            S_RD:
            begin
                if (lo_reg < hi_reg)
                begin
                    state_next = S_CMP;
                end
                else if (query_reg)
                begin
                    state_next = S_OUT;
                end
                else
                begin
                    idx_next   = cnt_reg;
                    state_next = S_SHRD;
                end
            end
            S_CMP:
            begin
                if (rdata <= key_reg)
                begin
                    lo_next = mid + 1'b1;
                end
                else
                begin
                    hi_next = mid;
                end
                state_next = S_RD;
            end
            S_SHRD:
            begin
                ra = idx_reg[ADR_W-1:0] - 1'b1;
                if (idx_reg == lo_reg)
                begin
                    we         = 1'b1;
                    cnt_next   = cnt_reg + 1'b1;
                    state_next = S_IDLE;
                end
                else
                begin
                    state_next = S_SHWR;
                end
            end
            S_SHWR:
            begin
                we         = 1'b1;
                wd         = rdata;
                idx_next   = idx_reg - 1'b1;
                state_next = S_SHRD;
            end
            S_OUT:
            begin
                if (!out_stall)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        idx_reg   <= idx_next;
        key_reg   <= key_next;
        query_reg <= query_next;
        lo_reg    <= lo_next;
        hi_reg    <= hi_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
            ovf_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            ovf_reg   <= ovf_next;
        end
    end

    a_onehot: assert property (@(posedge clk) disable iff (!rst_n) $onehot(state_reg))
        else $error("state not one-hot");
    a_cnt_cap: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CNT_W'(CAPACITY))
        else $error("store count above capacity");
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(count_le))
        else $error("result dropped");
endmodule

/* sv/count_less_or_equal_query.sv */
// count_less_or_equal_query: sorted store with upper-bound count queries.
// Query: binary search over the store, one RAM read per search step.
// Load: search, then shift each larger entry up one place (a RAM read and a write per entry).
// A two-entry queue decouples input from the search/insert engine.
// rst_n clears the count; store contents are not cleared.
`timescale 1ns / 1ps
module count_less_or_equal_query #(
    parameter int CAPACITY = clq_pkg::DEF_CAPACITY
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_stall,
    input  logic                               kind,
    input  logic signed [clq_pkg::DATA_W-1:0]  item_value,
    output logic                               out_valid,
    input  logic                               out_stall,
    output logic [clq_pkg::COUNT_W-1:0]        count_le,
    output logic                               overflow
);
    import clq_pkg::*;

    logic cmd_valid, cmd_take;
    cmd_t cmd;

    clq_front #(.CAPACITY(CAPACITY)) u_front (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
        .kind(kind), .item_value(item_value),
        .cmd_valid(cmd_valid), .cmd_take(cmd_take), .cmd(cmd)
    );

    clq_back #(.CAPACITY(CAPACITY)) u_back (
        .clk(clk), .rst_n(rst_n), .cmd_valid(cmd_valid), .cmd_take(cmd_take),
        .cmd(cmd), .out_valid(out_valid), .out_stall(out_stall),
        .count_le(count_le), .overflow(overflow)
    );
endmodule
